>>> rtl/dstm_pkg.sv
package dstm_pkg;

  localparam int LEVEL_INPUTS = 4;
  localparam int LEVEL_W      = 12;
  localparam int THR_W        = 12;
  localparam int LEN_W        = 13;
  localparam int ADDR_W       = 14;
  localparam int WORD_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 24;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2048);
  localparam logic [LEN_W-1:0] LENGTH_RESET    = LEN_W'(4096);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH0    = 3'd4;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_MUL,
    ST_OUT
  } back_state_e;

  typedef logic [LEVEL_INPUTS-1:0][THR_W-1:0] thr_arr_t;
  typedef logic [LEVEL_INPUTS-1:0][LEN_W-1:0] len_arr_t;

  // classified item handed from the front to the back
  typedef struct packed {
    cmd_kind_e                kind;
    logic                     left;
    logic [LEVEL_INPUTS-1:0]  above;
    logic [LEVEL_INPUTS-1:0]  below;
    logic [ADDR_W-1:0]        addr;
    logic signed [WORD_W-1:0] word;
  } cmd_t;

endpackage

>>> rtl/dstm_front.sv
module dstm_front #(
  parameter int LEVEL_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dstm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  dstm_pkg::thr_arr_t                  threshold_i,
  output logic                                cmd_valid_o,
  output dstm_pkg::cmd_t                      cmd_o,
  input  logic                                cmd_pop_i
);

  localparam logic [dstm_pkg::LEVEL_W-1:0] LevelMask =
    (LEVEL_BITS >= dstm_pkg::LEVEL_W) ? {dstm_pkg::LEVEL_W{1'b1}}
                                      : dstm_pkg::LEVEL_W'((1 << LEVEL_BITS) - 1);

  dstm_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;
  dstm_pkg::cmd_t cmd_in;
  logic [dstm_pkg::LEVEL_W-1:0] level;

  // classify the incoming item against the thresholds
  always_comb begin
    cmd_in       = '0;
    cmd_in.kind  = dstm_pkg::cmd_kind_e'(s_axis_tuser);
    cmd_in.left  = s_axis_tdata[48];
    cmd_in.addr  = s_axis_tdata[62:49];
    cmd_in.word  = s_axis_tdata[78:63];
    level        = '0;
    for (int v = 0; v < dstm_pkg::LEVEL_INPUTS; v++) begin
      level           = s_axis_tdata[v*dstm_pkg::LEVEL_W +: dstm_pkg::LEVEL_W] & LevelMask;
      cmd_in.above[v] = level > threshold_i[v];
      cmd_in.below[v] = level < threshold_i[v];
    end
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o   = (count_q != 2'd0);
  assign cmd_o         = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/dstm_back.sv
module dstm_back #(
  parameter int VOICES       = 4,
  parameter int REGION_WORDS = 4096,
  parameter int GAIN_Q8      = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  dstm_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  dstm_pkg::len_arr_t                  length_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dstm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int NV          = (VOICES < dstm_pkg::LEVEL_INPUTS) ? VOICES
                                                                  : dstm_pkg::LEVEL_INPUTS;
  localparam int StoreWords  = VOICES * REGION_WORDS;
  localparam int StoreDepth  = (StoreWords < (1 << dstm_pkg::ADDR_W)) ? StoreWords
                                                                      : (1 << dstm_pkg::ADDR_W);
  localparam int SAW         = $clog2(StoreDepth);
  localparam int PW          = $clog2(REGION_WORDS);
  localparam int BW          = $clog2(dstm_pkg::LEVEL_INPUTS * REGION_WORDS) + 1;
  localparam int SUM_W       = 20;
  localparam int PROD_W      = 32;
  localparam logic [1:0] LastVoice = 2'(NV - 1);
  localparam logic signed [PROD_W-1:0] Gain = PROD_W'(GAIN_Q8);

  localparam int VN = dstm_pkg::LEVEL_INPUTS;

  dstm_pkg::back_state_e state_q, state_d;

  logic [1:0]                       vc_q, vc_d;
  logic [BW-1:0]                    base_q, base_d;
  logic signed [SUM_W-1:0]          sum_q, sum_d;
  logic signed [PROD_W-1:0]         prod_q, prod_d;
  logic                             pend_q, pend_d;
  logic                             left_q, left_d;
  logic [VN-1:0]                    active_q, active_d;
  logic [VN-1:0]                    armed_q, armed_d;
  logic [PW-1:0]                    pos_q [VN];
  logic [PW-1:0]                    pos_d [VN];
  logic signed [dstm_pkg::WORD_W-1:0] held_q, held_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [dstm_pkg::WORD_W-1:0] out_mix_q, out_mix_d;
  logic [VN-1:0]                    out_mask_q, out_mask_d;

  logic signed [dstm_pkg::WORD_W-1:0] mem [StoreDepth];
  logic signed [dstm_pkg::WORD_W-1:0] rdata_q;

  logic                             mem_we;
  logic                             rd_en;
  logic [BW-1:0]                    rd_addr;
  logic [PW:0]                      pos_next;
  logic                             voice_stop;
  logic                             out_load;
  logic signed [dstm_pkg::WORD_W-1:0] mix_val;
  logic [VN-1:0]                    play_mask;

  function automatic logic signed [15:0] scale_clip(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] q;
    adj = p + ((p < 0) ? PROD_W'(255) : PROD_W'(0));
    q   = adj >>> 8;
    if (q > PROD_W'(32767)) begin
      scale_clip = 16'sh7fff;
    end else if (q < -PROD_W'(32768)) begin
      scale_clip = 16'sh8000;
    end else begin
      scale_clip = q[15:0];
    end
  endfunction

  assign cmd_pop_o = (state_q == dstm_pkg::ST_IDLE) && cmd_valid_i;
  assign mem_we    = cmd_pop_o && (cmd_i.kind == dstm_pkg::CMD_LOAD) &&
                     (32'(cmd_i.addr) < StoreDepth);

  always_comb begin
    for (int v = 0; v < VN; v++) begin
      play_mask[v] = (v < NV) ? active_q[v] : 1'b0;
    end
  end

  // current voice read and advance
  always_comb begin
    rd_addr    = base_q + BW'(pos_q[vc_q]);
    pos_next   = {1'b0, pos_q[vc_q]} + (PW+1)'(1);
    voice_stop = (32'(pos_next) >= 32'(length_i[vc_q])) || (32'(pos_next) >= REGION_WORDS);
    rd_en      = (state_q == dstm_pkg::ST_READ) && active_q[vc_q] &&
                 (32'(rd_addr) < StoreDepth);
  end

  assign mix_val  = left_q ? scale_clip(prod_q) : held_q;
  assign out_load = (state_q == dstm_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dstm_pkg::ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == dstm_pkg::CMD_TICK)) begin
          state_d = cmd_i.left ? dstm_pkg::ST_READ : dstm_pkg::ST_OUT;
        end
      end
      dstm_pkg::ST_READ: begin
        if (vc_q == LastVoice) begin
          state_d = dstm_pkg::ST_LAST;
        end
      end
      dstm_pkg::ST_LAST: state_d = dstm_pkg::ST_MUL;
      dstm_pkg::ST_MUL:  state_d = dstm_pkg::ST_OUT;
      dstm_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = dstm_pkg::ST_IDLE;
        end
      end
      default: state_d = dstm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    vc_d        = vc_q;
    base_d      = base_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    pend_d      = pend_q;
    left_d      = left_q;
    active_d    = active_q;
    armed_d     = armed_q;
    pos_d       = pos_q;
    held_d      = held_q;
    out_mix_d   = out_mix_q;
    out_mask_d  = out_mask_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      dstm_pkg::ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == dstm_pkg::CMD_TICK)) begin
          left_d = cmd_i.left;
          vc_d   = '0;
          base_d = '0;
          sum_d  = '0;
          pend_d = 1'b0;
          for (int v = 0; v < VN; v++) begin
            if (v < NV) begin
              if (cmd_i.above[v] && !armed_q[v]) begin
                armed_d[v]  = 1'b1;
                active_d[v] = 1'b1;
                pos_d[v]    = '0;
              end else if (cmd_i.below[v]) begin
                armed_d[v] = 1'b0;
              end
            end
          end
        end
      end
      dstm_pkg::ST_READ: begin
        // word of the previous voice lands now
        sum_d  = sum_q + (pend_q ? SUM_W'(rdata_q) : SUM_W'(0));
        pend_d = rd_en;
        if (active_q[vc_q]) begin
          if (voice_stop) begin
            active_d[vc_q] = 1'b0;
            pos_d[vc_q]    = '0;
          end else begin
            pos_d[vc_q] = pos_next[PW-1:0];
          end
        end
        vc_d   = vc_q + 2'd1;
        base_d = base_q + BW'(REGION_WORDS);
      end
      dstm_pkg::ST_LAST: begin
        sum_d  = sum_q + (pend_q ? SUM_W'(rdata_q) : SUM_W'(0));
        pend_d = 1'b0;
      end
      dstm_pkg::ST_MUL: begin
        prod_d = PROD_W'(sum_q) * Gain;
      end
      dstm_pkg::ST_OUT: begin
        if (out_load) begin
          held_d      = mix_val;
          out_mix_d   = mix_val;
          out_mask_d  = play_mask;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dstm_pkg::ST_IDLE;
      vc_q        <= '0;
      base_q      <= '0;
      sum_q       <= '0;
      prod_q      <= '0;
      pend_q      <= 1'b0;
      left_q      <= 1'b0;
      active_q    <= '0;
      armed_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      for (int v = 0; v < VN; v++) begin
        pos_q[v] <= '0;
      end
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      base_q      <= base_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      active_q    <= active_d;
      armed_q     <= armed_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mix_q  <= out_mix_d;
    out_mask_q <= out_mask_d;
  end

  // single-port sample store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.addr[SAW-1:0]] <= cmd_i.word;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr[SAW-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_mask_q, out_mix_q};

endmodule

>>> rtl/drum_sample_trigger_mixer_unit.sv
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/tready         tdata: levels, phase, load address/word
//                                                   tuser: mode (1 = load)
// m_axis    out        m_axis_tvalid/tready         tdata: mix_sample, playing_mask
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// a load is written in idle; a right tick goes from idle to out, a left tick through read, last, mul, out:
// the single-port sample store gives one voice word per cycle, then sum, scale, clip.
// a two-entry queue keeps taking items while the back end works, until both entries are full.
// reset clears voice state, held mix and registers; the sample store is not cleared
// and the user must load it before it is read; the block itself does not enforce this.
// with m_axis_tready low the result waits in the output register and the back end holds.
module drum_sample_trigger_mixer_unit #(
  parameter int VOICES       = 4,
  parameter int REGION_WORDS = 4096,
  parameter int GAIN_Q8      = 64,
  parameter int LEVEL_BITS   = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // level0[11:0] level1[23:12] level2[35:24] level3[47:36] left_phase[48]
  // load_address[62:49] load_word[78:63], bit 79 zero
  input  logic [dstm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mix_sample[15:0] playing_mask[19:16], bits 23:20 zero
  output logic [dstm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dstm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dstm_pkg::LEN_W-1:0]          cfg_data_i
);

  dstm_pkg::thr_arr_t thr_q, thr_d;
  dstm_pkg::len_arr_t len_q, len_d;
  logic               cmd_valid;
  dstm_pkg::cmd_t     cmd;
  logic               cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    len_d = len_q;
    if (cfg_valid_i) begin
      for (int v = 0; v < dstm_pkg::LEVEL_INPUTS; v++) begin
        if (v < VOICES) begin
          if (cfg_index_i == dstm_pkg::REG_THRESHOLD0 + dstm_pkg::CFG_IDX_W'(v)) begin
            thr_d[v] = cfg_data_i[dstm_pkg::THR_W-1:0];
          end
          if (cfg_index_i == dstm_pkg::REG_LENGTH0 + dstm_pkg::CFG_IDX_W'(v)) begin
            len_d[v] = cfg_data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < dstm_pkg::LEVEL_INPUTS; v++) begin
        thr_q[v] <= dstm_pkg::THRESHOLD_RESET;
        len_q[v] <= dstm_pkg::LENGTH_RESET;
      end
    end else begin
      thr_q <= thr_d;
      len_q <= len_d;
    end
  end

  dstm_front #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .threshold_i   (thr_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  dstm_back #(
    .VOICES       (VOICES),
    .REGION_WORDS (REGION_WORDS),
    .GAIN_Q8      (GAIN_Q8)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .length_i      (len_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
